// ===== design/czom_pkg.sv =====
// Package with shared types and constants of the cross-zone order matcher.
package czom_pkg;

  localparam logic [1:0] KIND_TRADE  = 2'd0;
  localparam logic [1:0] KIND_FINAL  = 2'd1;
  localparam logic [1:0] KIND_RULE   = 2'd2;

  localparam logic [1:0] ST_NEW      = 2'd0;
  localparam logic [1:0] ST_PARTIAL  = 2'd1;
  localparam logic [1:0] ST_FILLED   = 2'd2;

  localparam logic FUNC_ORDER = 1'b0;
  localparam logic FUNC_RULE  = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // Resting order held by one cell.
  typedef struct packed {
    logic        side;
    logic [3:0]  zone;
    logic [31:0] price;
    logic [31:0] left;
    logic [31:0] tag;
    logic [47:0] tm;
  } slot_t;

  // Candidate travelling down the cell chain during a scan.
  typedef struct packed {
    logic        found;
    logic [33:0] eff;
    logic [47:0] tm;
    logic        same_zone;
    logic [15:0] fee;
  } cand_t;

  // Search context broadcast to every cell during a scan.
  typedef struct packed {
    logic        side;
    logic [3:0]  zone;
    logic [33:0] limit;
  } ctx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RULE_RD,
    S_SCAN,
    S_FILL,
    S_FREE,
    S_OUT
  } state_t;

endpackage

// ===== design/czom_cell.sv =====
// One book slot: holds a resting order and ranks it against the incoming candidate.
module czom_cell
  import czom_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  slot_t       wr_slot,
  input  logic        fill_en,
  input  logic [31:0] fill_qty,
  input  logic        cmp_en,
  input  ctx_t        ctx,
  input  logic        rule_ok,
  input  logic [15:0] rule_fee,
  input  cand_t       cand_in,
  output cand_t       cand_out,
  output logic        take,
  output logic        valid,
  output slot_t       slot
);

  logic  valid_r;
  slot_t slot_r;
  logic  elig;
  logic  same;
  logic [15:0] fee;
  logic [33:0] eff;
  logic  better;

  assign valid = valid_r;
  assign slot  = slot_r;

  always_comb begin
    same = (slot_r.zone == ctx.zone);
    fee  = same ? 16'd0 : rule_fee;
    if (ctx.side == SIDE_BUY) begin
      eff = {2'b00, slot_r.price} + {18'd0, fee};
    end else begin
      eff = {2'b00, slot_r.price} - {18'd0, fee};
    end
    elig = valid_r && (slot_r.side != ctx.side) && (slot_r.left != 32'd0)
           && (same || rule_ok);
    if (ctx.side == SIDE_BUY) begin
      elig = elig && ($signed(eff) <= $signed(ctx.limit));
    end else begin
      elig = elig && ($signed(eff) >= $signed(ctx.limit));
    end
    // Cells are visited from slot zero up, so a full tie keeps the earlier (lower) slot.
    if (!elig) begin
      better = 1'b0;
    end else if (!cand_in.found) begin
      better = 1'b1;
    end else if (eff != cand_in.eff) begin
      better = (ctx.side == SIDE_BUY) ? ($signed(eff) < $signed(cand_in.eff))
                                      : ($signed(eff) > $signed(cand_in.eff));
    end else if (slot_r.tm != cand_in.tm) begin
      better = slot_r.tm < cand_in.tm;
    end else begin
      better = same && !cand_in.same_zone;
    end
    take = cmp_en && better;
    cand_out = cand_in;
    if (better) begin
      cand_out.found     = 1'b1;
      cand_out.eff       = eff;
      cand_out.tm        = slot_r.tm;
      cand_out.same_zone = same;
      cand_out.fee       = fee;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= 1'b1;
    end else if (fill_en && (slot_r.left == fill_qty)) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r <= wr_slot;
    end else if (fill_en) begin
      slot_r.left <= slot_r.left - fill_qty;
    end
  end

endmodule

// ===== design/czom_rules.sv =====
// Transfer rule table: allowed bits with reset, fees in a memory.
module czom_rules
  import czom_pkg::*;
#(
  parameter int ZONE_COUNT = 16
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [3:0]  wr_seller,
  input  logic [3:0]  wr_buyer,
  input  logic        wr_ok,
  input  logic [15:0] wr_fee,
  input  logic [3:0]  rd_seller,
  input  logic [3:0]  rd_buyer,
  output logic        rd_ok,
  output logic [15:0] rd_fee
);

  localparam int ENTRIES = ZONE_COUNT * ZONE_COUNT;
  localparam int AW = $clog2(ENTRIES);

  logic [ENTRIES-1:0] ok_r;
  logic [15:0]        fee_mem [ENTRIES];
  logic [AW-1:0]      wa;
  logic [AW-1:0]      ra;
  logic               wr_in;
  logic               rd_in;
  logic               rd_in_r;
  logic               rd_ok_r;
  logic [15:0]        fee_r;

  assign wr_in = (32'(wr_seller) < ZONE_COUNT) && (32'(wr_buyer) < ZONE_COUNT);
  assign rd_in = (32'(rd_seller) < ZONE_COUNT) && (32'(rd_buyer) < ZONE_COUNT);
  assign wa = AW'(32'(wr_seller) * ZONE_COUNT + 32'(wr_buyer));
  assign ra = AW'(32'(rd_seller) * ZONE_COUNT + 32'(rd_buyer));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= '0;
    end else if (wr_en && wr_in) begin
      ok_r[wa] <= wr_ok;
    end
  end

  // Fees start as zero in the model, but are used only when the allowed bit is set.
  always_ff @(posedge clk) begin
    if (wr_en && wr_in) begin
      fee_mem[wa] <= wr_fee;
    end
    fee_r   <= fee_mem[ra];
    rd_ok_r <= ok_r[ra];
    rd_in_r <= rd_in;
  end

  assign rd_ok  = rd_ok_r && rd_in_r;
  assign rd_fee = fee_r;

endmodule

// ===== design/cross_zone_order_matcher.sv =====
// Top level of the cross-zone order matcher: book cell chain, rule table and control.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_ready  | func side zone counter_zone price qty tag time rule
//  out_    | out | out_valid/out_ready| kind tags quantities price fee status last
//
// A rule write passes S_RULE_RD, then S_OUT. An order reads the fee of every zone
// pair one cell per cycle: each scan for a fill walks the cell chain and is followed
// by a fill step; when a remainder is left, a free-slot search comes before the
// final result.
// Reset clears the book valid bits and the allowed bits of the rule table.
// While a result waits on out_ready the next fill or final result holds; a new item
// is taken only in idle.
module cross_zone_order_matcher
  import czom_pkg::*;
#(
  parameter int BOOK_DEPTH = 32,
  parameter int ZONE_COUNT = 16
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic        in_side,
  input  logic [3:0]  in_zone,
  input  logic [3:0]  in_counter_zone,
  input  logic [31:0] in_limit_price,
  input  logic [31:0] in_order_quantity,
  input  logic [31:0] in_order_tag,
  input  logic [47:0] in_created_time,
  input  logic        in_rule_allowed,
  input  logic [15:0] in_rule_fee,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_resting_tag,
  output logic [31:0] out_trade_quantity,
  output logic [31:0] out_trade_price,
  output logic [15:0] out_trade_fee,
  output logic [31:0] out_resting_left,
  output logic        out_resting_done,
  output logic [31:0] out_incoming_left,
  output logic [1:0]  out_incoming_status,
  output logic        out_book_full,
  output logic        out_last
);

  localparam int IW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(BOOK_DEPTH + 1);

  state_t state_r, state_nxt;

  // Captured input item.
  logic        func_r;
  slot_t       ord_r;
  logic [31:0] qty_r;
  logic [3:0]  czone_r;
  logic        rok_r;
  logic [15:0] rfee_r;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] best_r;
  cand_t         cand_r;
  logic [CW-1:0] pos_r;  // cell compared in the current cycle, valid when cmp active

  // Result register.
  logic        ov_r;
  logic [1:0]  kind_r;
  logic [31:0] rtag_r, tqty_r, tprice_r, rleft_r, ileft_r;
  logic [15:0] tfee_r;
  logic        rdone_r, full_r, last_r;
  logic [1:0]  ist_r;

  // Cell array signals.
  slot_t cslot  [BOOK_DEPTH];
  logic  cvalid [BOOK_DEPTH];
  logic  ctake  [BOOK_DEPTH];
  cand_t cout   [BOOK_DEPTH];
  logic  ccmp   [BOOK_DEPTH];
  logic  cwr    [BOOK_DEPTH];
  logic  cfill  [BOOK_DEPTH];
  ctx_t  ctx;
  logic  rd_ok;
  logic [15:0] rd_fee;
  logic  cmp_act;
  logic [IW-1:0] cidx;
  logic [IW-1:0] ridx;
  slot_t bslot;
  logic [31:0] fq;
  logic        rule_wr;
  logic [3:0]  rd_seller, rd_buyer;

  assign ctx.side  = ord_r.side;
  assign ctx.zone  = ord_r.zone;
  assign ctx.limit = {2'b00, ord_r.price};

  // Fee lookup is registered and runs one cell ahead of the compare: cnt_r addresses, pos_r compares.
  assign ridx = (cnt_r < CW'(BOOK_DEPTH)) ? cnt_r[IW-1:0] : '0;
  assign rd_seller = (ord_r.side == SIDE_BUY) ? cslot[ridx].zone : ord_r.zone;
  assign rd_buyer  = (ord_r.side == SIDE_BUY) ? ord_r.zone : cslot[ridx].zone;
  assign rule_wr   = (state_r == S_RULE_RD);

  czom_rules #(.ZONE_COUNT(ZONE_COUNT)) u_rules (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (rule_wr),
    .wr_seller (ord_r.zone),
    .wr_buyer  (czone_r),
    .wr_ok     (rok_r),
    .wr_fee    (rfee_r),
    .rd_seller (rd_seller),
    .rd_buyer  (rd_buyer),
    .rd_ok     (rd_ok),
    .rd_fee    (rd_fee)
  );

  assign cmp_act = (state_r == S_SCAN) && (pos_r < CW'(BOOK_DEPTH)) && (cnt_r >= CW'(1));
  assign cidx    = pos_r[IW-1:0];
  assign bslot   = cslot[best_r];
  assign fq      = (qty_r < bslot.left) ? qty_r : bslot.left;

  for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
    assign ccmp[g]  = cmp_act && (cidx == IW'(g));
    assign cwr[g]   = (state_r == S_FREE) && (best_r == IW'(g)) && cand_r.found;
    assign cfill[g] = (state_r == S_FILL) && ov_r == 1'b0 && cand_r.found
                      && (best_r == IW'(g));
    czom_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (cwr[g]),
      .wr_slot  ({ord_r.side, ord_r.zone, ord_r.price, qty_r, ord_r.tag, ord_r.tm}),
      .fill_en  (cfill[g]),
      .fill_qty (fq),
      .cmp_en   (ccmp[g]),
      .ctx      (ctx),
      .rule_ok  (rd_ok),
      .rule_fee (rd_fee),
      .cand_in  (cand_r),
      .cand_out (cout[g]),
      .take     (ctake[g]),
      .valid    (cvalid[g]),
      .slot     (cslot[g])
    );
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_func == FUNC_RULE) begin
            state_nxt = S_RULE_RD;
          end else if (in_order_quantity == 32'd0) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_RULE_RD: state_nxt = S_OUT;
      S_SCAN: begin
        if (pos_r == CW'(BOOK_DEPTH - 1) && cnt_r >= CW'(1)) begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        if (!ov_r) begin
          state_nxt = (cand_r.found && qty_r > bslot.left) ? S_SCAN
                    : (cand_r.found ? S_OUT : S_FREE);
        end
      end
      S_FREE: begin
        if (pos_r == CW'(BOOK_DEPTH)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cnt_nxt = cnt_r + CW'(1);

  // Control and datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      if (ov_r && out_ready) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        S_FILL: if (!ov_r && cand_r.found) ov_r <= 1'b1;
        S_OUT:  if (!ov_r) ov_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        func_r     <= in_func;
        ord_r      <= {in_side, in_zone, in_limit_price, in_order_quantity,
                       in_order_tag, in_created_time};
        qty_r      <= in_order_quantity;
        czone_r    <= in_counter_zone;
        rok_r      <= in_rule_allowed;
        rfee_r     <= in_rule_fee;
        cnt_r      <= '0;
        pos_r      <= '0;
        cand_r     <= '0;
        best_r     <= '0;
      end
      S_SCAN: begin
        cnt_r <= cnt_nxt;
        if (cnt_r >= CW'(1)) begin
          pos_r  <= pos_r + CW'(1);
          cand_r <= cout[cidx];
          if (ctake[cidx]) begin
            best_r <= cidx;
          end
        end
      end
      S_FILL: begin
        if (!ov_r) begin
          cnt_r  <= '0;
          pos_r  <= '0;
          if (cand_r.found) begin
            kind_r   <= KIND_TRADE;
            rtag_r   <= bslot.tag;
            tqty_r   <= fq;
            tprice_r <= bslot.price;
            tfee_r   <= cand_r.fee;
            rleft_r  <= bslot.left - fq;
            rdone_r  <= (bslot.left == fq);
            ileft_r  <= qty_r - fq;
            ist_r    <= ST_NEW;
            full_r   <= 1'b0;
            last_r   <= 1'b0;
            qty_r    <= qty_r - fq;
            cand_r   <= '0;
          end
        end
      end
      S_FREE: begin
        // Lowest free slot: walk the cells from slot zero up and keep the first free one.
        if (pos_r < CW'(BOOK_DEPTH)) begin
          if (!cvalid[pos_r[IW-1:0]] && !cand_r.found) begin
            cand_r.found <= 1'b1;
            best_r       <= pos_r[IW-1:0];
          end
          pos_r <= pos_r + CW'(1);
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          cand_r <= '0;
          rtag_r <= '0; tqty_r <= '0; tprice_r <= '0; tfee_r <= '0;
          rleft_r <= '0; rdone_r <= 1'b0; last_r <= 1'b1;
          if (func_r == FUNC_RULE) begin
            kind_r <= KIND_RULE;
            ileft_r <= '0; ist_r <= ST_NEW; full_r <= 1'b0;
          end else begin
            kind_r  <= KIND_FINAL;
            ileft_r <= qty_r;
            ist_r   <= (qty_r == 32'd0) ? ST_FILLED
                     : ((qty_r == ord_r.left) ? ST_NEW : ST_PARTIAL);
            full_r  <= (qty_r != 32'd0) && !cand_r.found;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_kind            = kind_r;
  assign out_resting_tag     = rtag_r;
  assign out_trade_quantity  = tqty_r;
  assign out_trade_price     = tprice_r;
  assign out_trade_fee       = tfee_r;
  assign out_resting_left    = rleft_r;
  assign out_resting_done    = rdone_r;
  assign out_incoming_left   = ileft_r;
  assign out_incoming_status = ist_r;
  assign out_book_full       = full_r;
  assign out_last            = last_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE))
    else $error("input taken outside idle");
  a_trade_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_TRADE) |-> !out_last)
    else $error("trade item marked last");
  a_trade_qty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_TRADE) |-> (out_trade_quantity != 32'd0))
    else $error("empty trade");
  a_done_left: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_resting_done) |-> (out_resting_left == 32'd0))
    else $error("resting order removed with quantity left");

endmodule

// ===== tb/tb_cross_zone_order_matcher.sv =====
// Self-checking testbench for the cross-zone order matcher: book, rule table and fills.
module tb_cross_zone_order_matcher;
  import czom_pkg::*;

  localparam int DEPTH = 32;
  localparam int ZONES = 16;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] rtag;
    logic [31:0] qty;
    logic [31:0] price;
    logic [15:0] fee;
    logic [31:0] rleft;
    logic        rdone;
    logic [31:0] ileft;
    logic [1:0]  status;
    logic        full;
    logic        last;
  } fill_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic in_side = 1'b0;
  logic [3:0] in_zone = '0;
  logic [3:0] in_counter_zone = '0;
  logic [31:0] in_limit_price = '0;
  logic [31:0] in_order_quantity = '0;
  logic [31:0] in_order_tag = '0;
  logic [47:0] in_created_time = '0;
  logic in_rule_allowed = 1'b0;
  logic [15:0] in_rule_fee = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [31:0] out_resting_tag, out_trade_quantity, out_trade_price;
  logic [15:0] out_trade_fee;
  logic [31:0] out_resting_left, out_incoming_left;
  logic out_resting_done, out_book_full, out_last;
  logic [1:0] out_incoming_status;

  cross_zone_order_matcher #(.BOOK_DEPTH(DEPTH), .ZONE_COUNT(ZONES)) dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: the book and the rule table.
  logic        bk_valid [DEPTH];
  logic        bk_side  [DEPTH];
  logic [3:0]  bk_zone  [DEPTH];
  logic [31:0] bk_price [DEPTH];
  logic [31:0] bk_left  [DEPTH];
  logic [31:0] bk_tag   [DEPTH];
  logic [47:0] bk_time  [DEPTH];
  logic        pair_ok  [ZONES*ZONES];
  logic [15:0] pair_fee [ZONES*ZONES];

  fill_t expected_fills[$];
  int errors = 0;
  int n_items = 0, n_trades = 0, n_full = 0, n_results = 0;
  longint cycles = 0;
  logic [47:0] clock_ts = 48'd1000;

  // Fee of a seller/buyer zone pair; returns 0 if the transfer is not allowed.
  function automatic bit lookup_fee(input logic [3:0] s, input logic [3:0] b,
                                    output logic [15:0] f);
    f = '0;
    if (s == b) return 1'b1;
    if (!pair_ok[s*ZONES+b]) return 1'b0;
    f = pair_fee[s*ZONES+b];
    return 1'b1;
  endfunction

  task automatic queue_result(input fill_t r);
    expected_fills = {expected_fills, r};
  endtask

  task automatic predict_fills(input logic func, input logic side, input logic [3:0] zone,
                               input logic [3:0] czone, input logic [31:0] lim,
                               input logic [31:0] qty, input logic [31:0] tag,
                               input logic [47:0] tm, input logic allow,
                               input logic [15:0] rfee);
    logic [31:0] rem, q;
    logic [15:0] f, bfee;
    longint eff, beff;
    int best, slot;
    bit better;
    fill_t r;
    rem = qty;
    if (func == FUNC_RULE) begin
      pair_ok[zone*ZONES+czone] = allow;
      pair_fee[zone*ZONES+czone] = rfee;
      r = '0; r.kind = KIND_RULE; r.last = 1'b1;
      queue_result(r);
      return;
    end
    while (rem > 0) begin
      best = -1; beff = 0; bfee = '0;
      for (int i = 0; i < DEPTH; i++) begin
        if (!bk_valid[i] || bk_side[i] == side || bk_left[i] == 0) continue;
        if (side == SIDE_BUY) begin
          if (!lookup_fee(bk_zone[i], zone, f)) continue;
          eff = longint'(bk_price[i]) + longint'(f);
          if (eff > longint'(lim)) continue;
        end else begin
          if (!lookup_fee(zone, bk_zone[i], f)) continue;
          eff = longint'(bk_price[i]) - longint'(f);
          if (eff < longint'(lim)) continue;
        end
        if (best < 0) better = 1'b1;
        else if (eff != beff) better = (side == SIDE_BUY) ? (eff < beff) : (eff > beff);
        else if (bk_time[i] != bk_time[best]) better = bk_time[i] < bk_time[best];
        else better = (bk_zone[i] == zone) && (bk_zone[best] != zone);
        if (better) begin
          best = i; beff = eff; bfee = f;
        end
      end
      if (best < 0) break;
      q = (rem < bk_left[best]) ? rem : bk_left[best];
      rem -= q;
      bk_left[best] -= q;
      if (bk_left[best] == 0) bk_valid[best] = 1'b0;
      r = '0;
      r.kind = KIND_TRADE; r.rtag = bk_tag[best]; r.qty = q; r.price = bk_price[best];
      r.fee = bfee; r.rleft = bk_left[best]; r.rdone = (bk_left[best] == 0);
      r.ileft = rem;
      queue_result(r);
      n_trades++;
    end
    r = '0;
    r.kind = KIND_FINAL; r.ileft = rem; r.last = 1'b1;
    r.status = (rem == 0) ? ST_FILLED : ((rem == qty) ? ST_NEW : ST_PARTIAL);
    if (rem > 0) begin
      slot = -1;
      for (int i = 0; i < DEPTH; i++)
        if (!bk_valid[i]) begin
          slot = i;
          break;
        end
      if (slot < 0) begin
        r.full = 1'b1;
        n_full++;
      end else begin
        bk_valid[slot] = 1'b1; bk_side[slot] = side; bk_zone[slot] = zone;
        bk_price[slot] = lim; bk_left[slot] = rem; bk_tag[slot] = tag; bk_time[slot] = tm;
      end
    end
    queue_result(r);
  endtask

  // Sender bursts: a random count of items, mostly with a random gap before each burst.
  int burst_left = 0;

  task automatic send_item(input logic func, input logic side, input logic [3:0] zone,
                           input logic [3:0] czone, input logic [31:0] lim,
                           input logic [31:0] qty, input logic [31:0] tag,
                           input logic [47:0] tm, input logic allow,
                           input logic [15:0] rfee);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1; in_func <= func; in_side <= side; in_zone <= zone;
    in_counter_zone <= czone; in_limit_price <= lim; in_order_quantity <= qty;
    in_order_tag <= tag; in_created_time <= tm; in_rule_allowed <= allow;
    in_rule_fee <= rfee;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_fills(func, side, zone, czone, lim, qty, tag, tm, allow, rfee);
    n_items++;
  endtask

  task automatic send_order(input logic side, input logic [3:0] zone, input logic [31:0] lim,
                            input logic [31:0] qty, input logic [47:0] tm);
    send_item(FUNC_ORDER, side, zone, 4'($urandom), lim, qty, $urandom, tm,
              1'($urandom), 16'($urandom));
  endtask

  task automatic send_rule(input logic [3:0] s, input logic [3:0] b, input logic allow,
                           input logic [15:0] f);
    send_item(FUNC_RULE, 1'($urandom), s, b, $urandom, $urandom, $urandom,
              48'({$urandom, $urandom}), allow, f);
  endtask

  // Receiver stall pattern: alternating stretches of steady ready and random stalls.
  always @(posedge clk) begin
    cycles++;
    if (!rst_n) out_ready <= 1'b0;
    else if ((cycles / 500) % 3 == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    fill_t got, exp_r;
    if (rst_n && out_valid && out_ready) begin
      got = {out_kind, out_resting_tag, out_trade_quantity, out_trade_price, out_trade_fee,
             out_resting_left, out_resting_done, out_incoming_left, out_incoming_status,
             out_book_full, out_last};
      n_results++;
      if (expected_fills.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_fills.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (got.kind !== exp_r.kind)
            $display("%0t: kind exp %0d got %0d", $time, exp_r.kind, got.kind);
          if (got.rtag !== exp_r.rtag)
            $display("%0t: resting_tag exp %h got %h", $time, exp_r.rtag, got.rtag);
          if (got.qty !== exp_r.qty)
            $display("%0t: trade_quantity exp %h got %h", $time, exp_r.qty, got.qty);
          if (got.price !== exp_r.price)
            $display("%0t: trade_price exp %h got %h", $time, exp_r.price, got.price);
          if (got.fee !== exp_r.fee)
            $display("%0t: trade_fee exp %h got %h", $time, exp_r.fee, got.fee);
          if (got.rleft !== exp_r.rleft)
            $display("%0t: resting_left exp %h got %h", $time, exp_r.rleft, got.rleft);
          if (got.rdone !== exp_r.rdone)
            $display("%0t: resting_done exp %b got %b", $time, exp_r.rdone, got.rdone);
          if (got.ileft !== exp_r.ileft)
            $display("%0t: incoming_left exp %h got %h", $time, exp_r.ileft, got.ileft);
          if (got.status !== exp_r.status)
            $display("%0t: incoming_status exp %0d got %0d", $time, exp_r.status,
                     got.status);
          if (got.full !== exp_r.full)
            $display("%0t: book_full exp %b got %b", $time, exp_r.full, got.full);
          if (got.last !== exp_r.last)
            $display("%0t: last exp %b got %b", $time, exp_r.last, got.last);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [47:0] next_ts();
    clock_ts += 48'($urandom_range(0, 3));
    return clock_ts;
  endfunction

  task automatic test_directed();
    // Same-zone trades need no rule; cross-zone ones are refused until allowed.
    send_order(SIDE_SELL, 4'd2, 32'd100, 32'd10, next_ts());
    send_order(SIDE_BUY, 4'd3, 32'd200, 32'd5, next_ts());
    send_order(SIDE_BUY, 4'd2, 32'd100, 32'd4, next_ts());
    send_rule(4'd2, 4'd3, 1'b1, 16'd7);
    send_order(SIDE_BUY, 4'd3, 32'd200, 32'd2, next_ts());
    // Zero quantity order.
    send_order(SIDE_BUY, 4'd1, 32'hFFFF_FFFF, 32'd0, next_ts());
    // A sell with a large fee drives the effective bid negative.
    send_rule(4'd15, 4'd0, 1'b1, 16'hFFFF);
    send_order(SIDE_BUY, 4'd0, 32'd10, 32'd3, next_ts());
    send_order(SIDE_SELL, 4'd15, 32'd0, 32'd1, next_ts());
    // Same-zone rule is stored but ignored.
    send_rule(4'd5, 4'd5, 1'b1, 16'd99);
    send_order(SIDE_SELL, 4'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_order(SIDE_BUY, 4'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd0);
    send_order(SIDE_BUY, 4'd5, 32'hFFFF_FFFF, 32'd1, next_ts());
    send_rule(4'd2, 4'd3, 1'b0, 16'd0);
  endtask

  task automatic test_book_overflow();
    // Fill the book with low-priced buys, then push the remainder out.
    for (int i = 0; i < DEPTH + 2; i++)
      send_order(SIDE_BUY, 4'($urandom_range(0, 15)), 32'd1, 32'($urandom_range(1, 9)),
                 next_ts());
    // A sell sweep trades against every zone-0 buy in the book.
    send_order(SIDE_SELL, 4'd0, 32'd0, 32'hFFFF_FFFF, next_ts());
    send_order(SIDE_BUY, 4'd0, 32'd0, 32'hFFFF_FFFF, next_ts());
    send_order(SIDE_SELL, 4'd0, 32'd0, 32'hFFFF_FFFF, next_ts());
  endtask

  task automatic test_random_trading(input int count);
    logic [31:0] p, q;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0: send_rule(4'($urandom), 4'($urandom), 1'($urandom), 16'($urandom));
        1: send_rule(4'($urandom_range(0, 3)), 4'($urandom_range(0, 3)),
                     ($urandom_range(0, 3) != 0), 16'($urandom_range(0, 20)));
        2: send_order(1'($urandom), 4'($urandom), $urandom, $urandom,
                      48'({$urandom, $urandom}));
        default: begin
          // Dense price band and few zones keep the book crossing often.
          p = 32'($urandom_range(90, 130));
          q = ($urandom_range(0, 15) == 0) ? $urandom : 32'($urandom_range(0, 40));
          send_order(1'($urandom), 4'($urandom_range(0, 3)), p, q,
                     ($urandom_range(0, 3) == 0) ? clock_ts : next_ts());
        end
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) bk_valid[i] = 1'b0;
    for (int i = 0; i < ZONES*ZONES; i++) begin
      pair_ok[i] = 1'b0;
      pair_fee[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_book_overflow();
    test_random_trading(420);
    in_valid <= 1'b0;
    while (expected_fills.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d items (orders and rule writes), checked %0d results.", n_items, n_results);
    $display("Predicted %0d trades and %0d book-full drops.", n_trades, n_full);
    if (errors == 0 && expected_fills.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
